/* src/traffic_flow_statistics_unit_assert.svh */
// assertion macros used by the checker file
`ifndef TRAFFIC_FLOW_STATISTICS_UNIT_ASSERT_SVH
`define TRAFFIC_FLOW_STATISTICS_UNIT_ASSERT_SVH
// property that holds whenever reset is low
`define TFS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property that is checked during reset as well
`define TFS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* src/tfs_pkg.sv */
// types, codes and constants of the traffic flow statistics block
`default_nettype none
package tfs_pkg;
   localparam int unsigned ReqDataWidth = 80;
   localparam int unsigned RspDataWidth = 216;
   localparam int unsigned ShareWidth   = 14;
   localparam logic [13:0] ShareFull    = 14'd10000;
   localparam logic [15:0] LowPortLimit = 16'd1024;

   typedef enum logic [3:0] {
      OP_LENGTH   = 4'd0,
      OP_TCP      = 4'd1,
      OP_UDP      = 4'd2,
      OP_ICMP     = 4'd3,
      OP_RD_LEN   = 4'd4,
      OP_RD_TCP   = 4'd5,
      OP_RD_UDP   = 4'd6,
      OP_RD_ICMP  = 4'd7,
      OP_FINISH   = 4'd8
   } op_type;

   localparam logic [1:0] StatusDone    = 2'd0;
   localparam logic [1:0] StatusIgnored = 2'd1;
   localparam logic [1:0] StatusRange   = 2'd2;

   localparam logic CsrFlowEnable = 1'b0;
   localparam logic CsrMaxPort    = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // latch the accepted request
      logic clear_rd;  // clearing pass: write zero at sweep address
      logic rd_issue;  // read memories at request address
      logic compute;   // evaluate item from read data
      logic div_start; // start a share division
      logic [2:0] div_sel;
      logic finish_end; // clear the totals
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic need_div;  // item needs share divisions
      logic [2:0] div_last;
   } sts_type;
endpackage
`default_nettype wire

/* src/tfs_divider.sv */
// restoring divider for share = floor(10000 * part / whole), one bit a cycle
`default_nettype none
module tfs_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] part,
   input  wire logic [63:0] whole,
   output logic             done,
   output logic [13:0]      share
);
   logic [77:0] num_ff, num_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] whole_ff, whole_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [13:0] q_ff, q_in;
   logic [64:0] trial;

   // part * 10000 as shifts and adds: 8192+1024+512+256+16
   function automatic logic [77:0] times_full(input logic [63:0] p);
      logic [77:0] x;
      x = {14'd0, p};
      return (x << 13) + (x << 10) + (x << 9) + (x << 8) + (x << 4);
   endfunction

   assign trial = {rem_ff[63:0], num_ff[77]};

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; whole_in = whole_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0; q_in = q_ff;
      if (start) begin
         whole_in = whole;
         rem_in = '0;
         cnt_in = 7'd0;
         q_in = '0;
         if (whole == 64'd0) begin
            done_in = 1'b1;
         end else if (part >= whole) begin
            q_in = tfs_pkg::ShareFull; done_in = 1'b1;
         end else begin
            num_in = times_full(part); busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         num_in = {num_ff[76:0], 1'b0};
         // quotient < 10000 fits 14 bits; only low bits kept
         if (trial >= {1'b0, whole_ff}) begin
            rem_in = trial - {1'b0, whole_ff};
            q_in = {q_ff[12:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[12:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd77) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; whole_ff <= whole_in;
      cnt_ff <= cnt_in; q_ff <= q_in;
   end

   assign done  = done_ff;
   assign share = q_ff;
endmodule
`default_nettype wire

/* src/tfs_datapath.sv */
// memories, totals, share divider and result register
`default_nettype none
module tfs_datapath #(
   parameter int unsigned LENGTH_BINS  = 4096,
   parameter int unsigned PORT_ENTRIES = 65536,
   parameter int unsigned ICMP_TYPES   = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tfs_pkg::cmd_type      cmd,
   output tfs_pkg::sts_type           sts,
   input  wire logic [tfs_pkg::ReqDataWidth-1:0] req_data,
   input  wire logic                  flow_enable,
   input  wire logic [16:0]           max_port,
   output logic [tfs_pkg::RspDataWidth-1:0] rsp_data
);
   localparam int unsigned LenW  = $clog2(LENGTH_BINS);
   localparam int unsigned PortW = $clog2(PORT_ENTRIES);
   localparam int unsigned IcmpW = $clog2(ICMP_TYPES);
   localparam int unsigned SweepW = (PortW > LenW) ? PortW : LenW;

   logic [63:0] len_mem [LENGTH_BINS];
   logic [63:0] tsrc_mem [PORT_ENTRIES];
   logic [63:0] tdst_mem [PORT_ENTRIES];
   logic [63:0] usrc_mem [PORT_ENTRIES];
   logic [63:0] udst_mem [PORT_ENTRIES];
   logic [63:0] icmp_mem [ICMP_TYPES];

   // request fields
   logic [3:0]  op_ff;
   logic [15:0] sp_ff, dp_ff, len_ff, idx_ff;
   logic [7:0]  ty_ff;
   logic        rb_ff;

   logic [63:0] rd_len_ff, rd_ts_ff, rd_td_ff, rd_us_ff, rd_ud_ff, rd_ic_ff;
   logic [63:0] pkt_ff, byt_ff, tcp_ff, tcph_ff, udp_ff, udph_ff, icmp_ff;
   logic [SweepW:0] sweep_ff;

   // per-item evaluation results
   logic [1:0]  st_ff;
   logic [63:0] c1_ff, c2_ff, sum_ff, tot_ff, other_ff;
   logic        need_ff;
   logic [13:0] sh_ff [6];
   logic        nonport_ff;

   // combinational evaluation
   logic [63:0] c1_c, c2_c, tot_c, sum_c;
   logic [1:0]  st_c;
   logic        above_c, range_c, upd_c, cnt_nz;
   logic [73:0] k1000;
   logic [65:0] ps;

   always_comb begin
      c1_c = '0; c2_c = '0; tot_c = '0; st_c = tfs_pkg::StatusDone; range_c = 1'b0;
      upd_c = 1'b0;
      unique case (op_ff)
         tfs_pkg::OP_LENGTH:
            if (rb_ff || ({16'd0, len_ff} >= 32'(LENGTH_BINS))) st_c = tfs_pkg::StatusIgnored;
            else upd_c = 1'b1;
         tfs_pkg::OP_TCP, tfs_pkg::OP_UDP, tfs_pkg::OP_ICMP:
            if (!flow_enable) st_c = tfs_pkg::StatusIgnored;
            else upd_c = 1'b1;
         tfs_pkg::OP_RD_LEN: begin
            range_c = {16'd0, idx_ff} >= 32'(LENGTH_BINS);
            c1_c = rd_len_ff; tot_c = pkt_ff;
         end
         tfs_pkg::OP_RD_TCP, tfs_pkg::OP_RD_UDP: begin
            range_c = ({1'b0, idx_ff} >= max_port) ||
                      ({16'd0, idx_ff} >= 32'(PORT_ENTRIES));
            c1_c = (op_ff == tfs_pkg::OP_RD_TCP) ? rd_ts_ff : rd_us_ff;
            c2_c = (op_ff == tfs_pkg::OP_RD_TCP) ? rd_td_ff : rd_ud_ff;
            tot_c = (op_ff == tfs_pkg::OP_RD_TCP) ? tcp_ff : udp_ff;
         end
         tfs_pkg::OP_RD_ICMP: begin
            range_c = {16'd0, idx_ff} >= 32'(ICMP_TYPES);
            c1_c = rd_ic_ff; tot_c = icmp_ff;
         end
         tfs_pkg::OP_FINISH: tot_c = byt_ff;
         default: st_c = tfs_pkg::StatusRange;
      endcase
      if (range_c) begin
         st_c = tfs_pkg::StatusRange; c1_c = '0; c2_c = '0;
      end
      sum_c = c1_c + c2_c;
      cnt_nz = sum_c != 64'd0;
      k1000 = ({10'd0, sum_c} << 10) - ({10'd0, sum_c} << 4) - ({10'd0, sum_c} << 3);
      above_c = cnt_nz && ((k1000[73:64] != 10'd0) || (k1000[63:0] > tot_c));
      ps = {2'b0, tcp_ff} + {2'b0, udp_ff} + {2'b0, icmp_ff};
   end

   // divider operand select
   logic [63:0] dv_part, dv_whole;
   logic [13:0] dv_share;
   logic        dv_done;
   always_comb begin
      unique case (cmd.div_sel)
         3'd0: begin dv_part = nonport_ff ? c1_ff : sum_ff;
            dv_whole = tot_ff; end
         3'd1: begin dv_part = c1_ff; dv_whole = sum_ff; end
         3'd2: begin dv_part = c2_ff; dv_whole = sum_ff; end
         3'd3: begin dv_part = other_ff; dv_whole = tot_ff; end
         3'd4: begin dv_part = tcph_ff; dv_whole = tcp_ff; end
         3'd5: begin dv_part = udph_ff; dv_whole = udp_ff; end
         default: begin dv_part = '0; dv_whole = '0; end
      endcase
      if (op_ff == tfs_pkg::OP_FINISH) begin
         unique case (cmd.div_sel)
            3'd0: dv_part = tcp_ff;
            3'd1: begin dv_part = udp_ff; dv_whole = byt_ff; end
            3'd2: begin dv_part = icmp_ff; dv_whole = byt_ff; end
            default: ;
         endcase
      end
   end

   tfs_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .part(dv_part), .whole(dv_whole), .done(dv_done), .share(dv_share)
   );

   logic [2:0] div_sel_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_start) div_sel_ff <= cmd.div_sel;
   end

   // sweep counter for clearing after reset
   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= '0;
      else if (cmd.clear_rd && !sweep_ff[SweepW]) sweep_ff <= sweep_ff + 1'b1;
   end

   // memories: one port write, registered read
   logic [PortW-1:0] sa, da, ia, wa;
   logic [LenW-1:0]  la;
   logic [IcmpW-1:0] ta;
   logic s_low, d_low, add_s, add_d;
   assign s_low = sp_ff < tfs_pkg::LowPortLimit;
   assign d_low = dp_ff < tfs_pkg::LowPortLimit;
   assign add_s = (s_low || !d_low) && ({16'd0, sp_ff} < 32'(PORT_ENTRIES));
   assign add_d = (d_low || !s_low) && ({16'd0, dp_ff} < 32'(PORT_ENTRIES));
   assign sa = sp_ff[PortW-1:0];
   assign da = dp_ff[PortW-1:0];
   assign ia = idx_ff[PortW-1:0];
   assign wa = sweep_ff[PortW-1:0];
   assign la = cmd.clear_rd ? sweep_ff[LenW-1:0] :
               (op_ff == tfs_pkg::OP_LENGTH) ? len_ff[LenW-1:0] : idx_ff[LenW-1:0];
   assign ta = cmd.clear_rd ? sweep_ff[IcmpW-1:0] :
               (op_ff == tfs_pkg::OP_ICMP) ? ty_ff[IcmpW-1:0] : idx_ff[IcmpW-1:0];

   logic wr_upd, wr_clr;
   assign wr_upd = cmd.compute && upd_c;
   assign wr_clr = cmd.compute && !range_c;

   // updates read in rd_issue and write back in compute
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_len_ff <= len_mem[la];
         rd_ic_ff  <= icmp_mem[ta];
         rd_ts_ff  <= tsrc_mem[(op_ff == tfs_pkg::OP_TCP) ? sa : ia];
         rd_td_ff  <= tdst_mem[(op_ff == tfs_pkg::OP_TCP) ? da : ia];
         rd_us_ff  <= usrc_mem[(op_ff == tfs_pkg::OP_UDP) ? sa : ia];
         rd_ud_ff  <= udst_mem[(op_ff == tfs_pkg::OP_UDP) ? da : ia];
      end
      if (cmd.clear_rd) begin
         if (sweep_ff < (SweepW+1)'(LENGTH_BINS)) len_mem[la] <= '0;
         if (sweep_ff < (SweepW+1)'(ICMP_TYPES)) icmp_mem[ta] <= '0;
         if (sweep_ff < (SweepW+1)'(PORT_ENTRIES)) begin
            tsrc_mem[wa] <= '0; tdst_mem[wa] <= '0;
            usrc_mem[wa] <= '0; udst_mem[wa] <= '0;
         end
      end else if (cmd.compute) begin
         unique case (op_ff)
            tfs_pkg::OP_LENGTH: if (wr_upd) len_mem[la] <= rd_len_ff + 64'd1;
            tfs_pkg::OP_ICMP: if (wr_upd) icmp_mem[ta] <= rd_ic_ff + {48'd0, len_ff};
            tfs_pkg::OP_TCP: if (wr_upd) begin
               // same port both sides: src and dst tables differ, no clash
               if (add_s) tsrc_mem[sa] <= rd_ts_ff + {48'd0, len_ff};
               if (add_d) tdst_mem[da] <= rd_td_ff + {48'd0, len_ff};
            end
            tfs_pkg::OP_UDP: if (wr_upd) begin
               if (add_s) usrc_mem[sa] <= rd_us_ff + {48'd0, len_ff};
               if (add_d) udst_mem[da] <= rd_ud_ff + {48'd0, len_ff};
            end
            tfs_pkg::OP_RD_LEN: if (wr_clr) len_mem[la] <= '0;
            tfs_pkg::OP_RD_ICMP: if (wr_clr) icmp_mem[ta] <= '0;
            tfs_pkg::OP_RD_TCP: if (wr_clr) begin
               tsrc_mem[ia] <= '0; tdst_mem[ia] <= '0; end
            tfs_pkg::OP_RD_UDP: if (wr_clr) begin
               usrc_mem[ia] <= '0; udst_mem[ia] <= '0; end
            default: ;
         endcase
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data[3:0];
         sp_ff  <= req_data[19:4];
         dp_ff  <= req_data[35:20];
         ty_ff  <= req_data[43:36];
         len_ff <= req_data[59:44];
         rb_ff  <= req_data[60];
         idx_ff <= req_data[76:61];
      end
   end

   // totals
   always_ff @(posedge clock) begin
      if (reset || cmd.finish_end) begin
         pkt_ff <= '0; byt_ff <= '0; tcp_ff <= '0; tcph_ff <= '0;
         udp_ff <= '0; udph_ff <= '0; icmp_ff <= '0;
      end else if (wr_upd) begin
         unique case (op_ff)
            tfs_pkg::OP_LENGTH: begin
               pkt_ff <= pkt_ff + 64'd1; byt_ff <= byt_ff + {48'd0, len_ff}; end
            tfs_pkg::OP_TCP: begin
               tcp_ff <= tcp_ff + {48'd0, len_ff};
               if (!s_low && !d_low) tcph_ff <= tcph_ff + {48'd0, len_ff};
            end
            tfs_pkg::OP_UDP: begin
               udp_ff <= udp_ff + {48'd0, len_ff};
               if (!s_low && !d_low) udph_ff <= udph_ff + {48'd0, len_ff};
            end
            tfs_pkg::OP_ICMP: icmp_ff <= icmp_ff + {48'd0, len_ff};
            default: ;
         endcase
      end
   end

   // item evaluation and share collection
   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         st_ff <= st_c; c1_ff <= c1_c; c2_ff <= c2_c; sum_ff <= sum_c;
         tot_ff <= tot_c;
         nonport_ff <= (op_ff != tfs_pkg::OP_RD_TCP) && (op_ff != tfs_pkg::OP_RD_UDP);
         other_ff <= (ps[65:64] != 2'd0 || ps[63:0] >= byt_ff) ? 64'd0 :
                     byt_ff - ps[63:0];
         need_ff <= (op_ff == tfs_pkg::OP_FINISH) || (above_c && !range_c &&
                    (op_ff == tfs_pkg::OP_RD_LEN || op_ff == tfs_pkg::OP_RD_TCP ||
                     op_ff == tfs_pkg::OP_RD_UDP || op_ff == tfs_pkg::OP_RD_ICMP));
         for (int i = 0; i < 6; i++) sh_ff[i] <= '0;
      end else if (dv_done) begin
         sh_ff[div_sel_ff] <= dv_share;
      end
   end

   assign sts.clear_done = sweep_ff[SweepW];
   assign sts.div_done   = dv_done;
   assign sts.need_div   = need_ff;
   assign sts.div_last   = (op_ff == tfs_pkg::OP_FINISH) ? 3'd5 :
                           nonport_ff ? 3'd0 : 3'd2;

   assign rsp_data = {2'b00, sh_ff[5], sh_ff[4], sh_ff[3], sh_ff[2], sh_ff[1],
                      sh_ff[0], c2_ff, c1_ff, st_ff};
endmodule
`default_nettype wire

/* src/tfs_controller.sv */
// sequencer: clearing pass, read-modify-write, share divisions, result handoff
`default_nettype none
module tfs_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic             op_finish,
   output tfs_pkg::cmd_type      cmd,
   input  wire tfs_pkg::sts_type sts
);
   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_EVAL  = 7'b0001000,
      ST_DSTRT = 7'b0010000,
      ST_DWAIT = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] sel_ff, sel_in;

   always_comb begin
      state_in = state_ff; sel_in = sel_ff; cmd = '0;
      cmd.div_sel = sel_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_rd = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: if (req_tvalid) begin cmd.load = 1'b1; state_in = ST_READ; end
         ST_READ: begin cmd.rd_issue = 1'b1; state_in = ST_EVAL; end
         ST_EVAL: begin cmd.compute = 1'b1; sel_in = 3'd0; state_in = ST_DSTRT; end
         ST_DSTRT: if (sts.need_div) begin
               cmd.div_start = 1'b1; state_in = ST_DWAIT;
            end else state_in = ST_OUT;
         ST_DWAIT: if (sts.div_done) begin
               if (sel_ff == sts.div_last) state_in = ST_OUT;
               else begin sel_in = sel_ff + 3'd1; state_in = ST_DSTRT; end
            end
         ST_OUT: if (rsp_tready) begin
               if (op_finish) cmd.finish_end = 1'b1;
               state_in = ST_IDLE;
            end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin state_ff <= ST_CLEAR; sel_ff <= '0; end
      else begin state_ff <= state_in; sel_ff <= sel_in; end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
endmodule
`default_nettype wire

/* src/traffic_flow_statistics_unit.sv */
// top level of the traffic flow statistics block
// Usage: items enter on req_ (op, ports, icmp type, length, rebuilt flag, index)
// and each gives one result on rsp_ (status, two counts, six shares).
// Registers flow_enable (index 0) and max_port_to_track (index 1) are written on
// the csr_ channel; the user must write them while the block is idle (not enforced).
// One item at a time: after the request transfer the block reads the memories,
// writes back and starts the share step before result valid rises, and the next
// request is taken the cycle after the result transfer.
// A read or finish item runs one division per share to divide, in turn (1 for
// length or icmp reads, 3 for port reads, 6 for finish); reads below the share
// threshold skip the divisions.
// After reset a clearing pass zeroes all tables, one address a cycle, sweeping the
// addresses below the larger of PORT_ENTRIES and LENGTH_BINS (65536 by default);
// no request is taken meanwhile, csr writes are.
// The result stays on rsp_ until taken; the block accepts no new request
// while the receiver stalls.
`default_nettype none
module traffic_flow_statistics_unit #(
   parameter int unsigned LENGTH_BINS  = 4096,
   parameter int unsigned PORT_ENTRIES = 65536,
   parameter int unsigned ICMP_TYPES   = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // op[3:0] src_port[19:4] dst_port[35:20] icmp_type[43:36]
   // byte_length[59:44] rebuilt[60] bin_index[76:61], zero fill
   input  wire logic [tfs_pkg::ReqDataWidth-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0] first_count[65:2] second_count[129:66] share_a[143:130]
   // share_b[157:144] share_c[171:158] share_d[185:172] share_e[199:186]
   // share_f[213:200], zero fill
   output logic [tfs_pkg::RspDataWidth-1:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [16:0]  csr_data
);
   logic        flow_enable_ff;
   logic [16:0] max_port_ff;
   tfs_pkg::cmd_type cmd;
   tfs_pkg::sts_type sts;
   logic [3:0] op_hold_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flow_enable_ff <= 1'b1; max_port_ff <= 17'd1024;
      end else if (csr_valid) begin
         unique case (csr_index)
            tfs_pkg::CsrFlowEnable: flow_enable_ff <= csr_data[0];
            tfs_pkg::CsrMaxPort:    max_port_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) op_hold_ff <= req_tdata[3:0];
   end

   tfs_controller u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .op_finish(op_hold_ff == tfs_pkg::OP_FINISH), .cmd(cmd), .sts(sts)
   );

   tfs_datapath #(
      .LENGTH_BINS(LENGTH_BINS), .PORT_ENTRIES(PORT_ENTRIES), .ICMP_TYPES(ICMP_TYPES)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_data(req_tdata),
      .flow_enable(flow_enable_ff), .max_port(max_port_ff), .rsp_data(rsp_tdata)
   );
endmodule
`default_nettype wire

/* src/tfs_checker.sv */
// port-level checks of the traffic flow statistics block
`default_nettype none
`include "traffic_flow_statistics_unit_assert.svh"
module tfs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [tfs_pkg::RspDataWidth-1:0] rsp_tdata
);
   `TFS_ASSERT(a_one_item, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "request taken while busy")
   `TFS_ASSERT(a_no_overlap, clock, reset, rsp_tvalid |-> !req_tready, "request ready with result pending")
   `TFS_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result dropped")
   `TFS_ASSERT(a_status, clock, reset, rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3), "bad status")
   `TFS_ASSERT_ALWAYS(a_reset, clock, reset |=> !rsp_tvalid, "result after reset")
endmodule
bind traffic_flow_statistics_unit tfs_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
